[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent property checks with a clock, an active-low reset and an
// implication. Both macros compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/icv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_pkg
// Types and constants shared by the 3x3 convolution modules.
// ----------------------------------------------------------------------------
package icv_pkg;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned COEF_W       = 8;
  localparam int unsigned DIM_W        = 11;
  localparam int unsigned ROW_W        = 10;
  localparam int unsigned DIM_RESET    = 1024;
  localparam int unsigned HEIGHT_LIMIT = 1024;
  localparam int unsigned MIN_DIM      = 3;
  localparam int unsigned DIV_W        = 8;
  localparam int unsigned PROD_W       = 17;  // s8 coef * u8 pixel
  localparam int unsigned SUM_W        = 20;  // nine products, signed
  localparam int unsigned MAG_W        = 19;  // |sum| <= 9 * 128 * 255

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_DIVISOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MID     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT     = 3'd5;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  // one kernel row: element j holds k[i][j]
  typedef logic [2:0][COEF_W-1:0] coef_row_t;
  // whole kernel: element i is row i
  typedef coef_row_t [2:0] coef_mat_t;

  // control that travels with an item down the pipe
  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

endpackage

[rtl/icv_line_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_line_mem
// Single-port-write, single-port-read line store with registered read data.
// ----------------------------------------------------------------------------
module icv_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 16
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/icv_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_window
// 3x3 window assembly, line store write-back, kernel products and row sums.
// ----------------------------------------------------------------------------
module icv_window (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                act_i,
  input  icv_pkg::tag_t                       tag_i,
  input  logic [icv_pkg::PIX_W-1:0]           px_i,
  input  logic [2*icv_pkg::PIX_W-1:0]         line_i,
  input  icv_pkg::coef_mat_t                  coef_i,
  output logic [2*icv_pkg::PIX_W-1:0]         wr_data_o,
  output logic signed [icv_pkg::SUM_W-1:0]    row_sum_o [3],
  output icv_pkg::tag_t                       tag_o
);
  import icv_pkg::*;

  logic [PIX_W-1:0]        win [3][3];
  logic [PIX_W-1:0]        win_q [3][2];
  logic signed [PROD_W-1:0] prod_d [3][3];
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [SUM_W-1:0]  row_sum_d [3];
  logic signed [SUM_W-1:0]  row_sum_q [3];
  tag_t                     tag2_q, tag3_q;

  // line word: upper byte two lines up, lower byte one line up
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win_q[r][0];
      win[r][1] = win_q[r][1];
    end
    win[0][2] = line_i[2*PIX_W-1:PIX_W];
    win[1][2] = line_i[PIX_W-1:0];
    win[2][2] = px_i;
  end

  assign wr_data_o = {line_i[PIX_W-1:0], px_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= '0;
        win_q[r][1] <= '0;
      end
    end else if (en_i && act_i) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win[r][1];
        win_q[r][1] <= win[r][2];
      end
    end
  end

  // flipped kernel: k[i][j] meets the pixel at row 2-i, column 2-j
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] =
          $signed({{(PROD_W-COEF_W){coef_i[i][j][COEF_W-1]}}, coef_i[i][j]}) *
          $signed({{(PROD_W-PIX_W){1'b0}}, win[2-i][2-j]});
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_sum_d[i] = SUM_W'(prod_q[i][0]) + SUM_W'(prod_q[i][1]) + SUM_W'(prod_q[i][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag2_q <= '0;
      tag3_q <= '0;
    end else if (en_i) begin
      tag2_q <= tag_i;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= prod_d;
      row_sum_q <= row_sum_d;
    end
  end

  assign row_sum_o = row_sum_q;
  assign tag_o     = tag3_q;

endmodule

[rtl/icv_div.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// icv_div
// Final sum, magnitude, saturation test and a pipelined restoring divider
// that retires one quotient bit per stage.
// ----------------------------------------------------------------------------
module icv_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [icv_pkg::DIV_W-1:0]         div_i,
  input  logic signed [icv_pkg::SUM_W-1:0]  row_sum_i [3],
  input  icv_pkg::tag_t                     tag_i,
  output logic                              valid_o,
  output logic [icv_pkg::PIX_W-1:0]         pixel_o,
  output logic                              last_o
);
  import icv_pkg::*;

  localparam int unsigned STEPS = PIX_W;
  localparam int unsigned HI_W  = MAG_W - PIX_W;

  logic signed [SUM_W-1:0] sum_q;
  tag_t                    tag_a_q;
  logic [SUM_W-1:0]        mag_full;
  logic [MAG_W-1:0]        mag;
  logic                    sat_d;

  logic [DIV_W-1:0] rem_q [STEPS+1];
  logic [PIX_W-1:0] low_q [STEPS+1];
  logic [PIX_W-1:0] quo_q [STEPS+1];
  logic             sat_q [STEPS+1];
  tag_t             tag_q [STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q  <= '0;
      tag_q[0] <= '0;
    end else if (en_i) begin
      tag_a_q  <= tag_i;
      tag_q[0] <= tag_a_q;
    end
  end

  assign mag_full = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign mag      = mag_full[MAG_W-1:0];
  // quotient above 255 iff floor(mag / 256) >= div
  assign sat_d    = mag[MAG_W-1:PIX_W] >= HI_W'(div_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q    <= row_sum_i[0] + row_sum_i[1] + row_sum_i[2];
      rem_q[0] <= mag[PIX_W +: DIV_W];
      low_q[0] <= mag[PIX_W-1:0];
      quo_q[0] <= '0;
      sat_q[0] <= sat_d;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           ge;

    assign trial = {rem_q[k], low_q[k][PIX_W-1]};
    assign diff  = trial - {1'b0, div_i};
    assign ge    = trial >= {1'b0, div_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k+1] <= '0;
      end else if (en_i) begin
        tag_q[k+1] <= tag_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        low_q[k+1] <= {low_q[k][PIX_W-2:0], 1'b0};
        quo_q[k+1] <= {quo_q[k][PIX_W-2:0], ge};
        sat_q[k+1] <= sat_q[k];
      end
    end
  end

  assign valid_o = tag_q[STEPS].valid;
  assign last_o  = tag_q[STEPS].last;
  assign pixel_o = sat_q[STEPS] ? PIX_MAX : quo_q[STEPS];

  // partial remainder of a live, unsaturated item never reaches the divisor
  for (genvar k = 0; k <= STEPS; k++) begin : g_chk
    `ASSERT_IMPLY(a_rem_below_div, clk_i, rst_ni, tag_q[k].valid && !sat_q[k], rem_q[k] < div_i)
  end

endmodule

[rtl/image_convolution_3x3.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// image_convolution_3x3
// 3x3 convolution over a raster stream of 8-bit grey pixels.
// ----------------------------------------------------------------------------
// Pixels enter on in_valid_i / in_stall_o / pixel_in_i in raster order; a beat
// moves on an edge where valid is high and stall is low. Results leave on
// out_valid_o / out_stall_i with pixel_out_o and frame_end_o, one beat per
// interior window, so an image of W x H pixels gives (W-2) x (H-2) results.
// frame_end_o marks the last result of an image.
// Throughput: one pixel per clock while no result is held by a stall. Both
// line stores live in one memory word per column, read on the accept edge
// and written back on the next edge at which the pipe advances.
// A pixel's result reaches the output through the line store read, products,
// row sums, total, magnitude and 8 divider stages.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall_o goes high in the same cycle; nothing is dropped.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (width,
// height, divisor, three kernel rows); write only while the pipe is empty.
// Reset: counters and window cleared, registers to width 1024, height 1024,
// divisor 1, zero kernel. Line stores are not cleared; no clearing pass.
// ----------------------------------------------------------------------------
module image_convolution_3x3 #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [icv_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [icv_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [icv_pkg::PIX_W-1:0]         pixel_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [icv_pkg::PIX_W-1:0]         pixel_out_o,
  output logic                              frame_end_o
);
  import icv_pkg::*;

  localparam int unsigned AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WCW = (AW + 1 > DIM_W) ? AW + 1 : DIM_W;

  // configuration
  logic [DIM_W-1:0] width_q, height_q;
  logic [DIV_W-1:0] norm_q;
  coef_mat_t        coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(DIM_RESET);
      height_q <= DIM_W'(DIM_RESET);
      norm_q   <= DIV_W'(1);
      coef_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q   <= cfg_wdata_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_q  <= cfg_wdata_i[DIM_W-1:0];
        REG_NORM_DIVISOR: norm_q    <= cfg_wdata_i[DIV_W-1:0];
        REG_COEF_TOP:     coef_q[0] <= cfg_wdata_i;
        REG_COEF_MID:     coef_q[1] <= cfg_wdata_i;
        REG_COEF_BOT:     coef_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [WCW-1:0]   width_ext, width_eff, last_col;
  logic [DIM_W-1:0] height_eff, last_row_full;
  logic [ROW_W-1:0] last_row;
  logic [DIV_W-1:0] div_eff;

  assign width_ext = WCW'(width_q);

  always_comb begin
    width_eff = width_ext;
    if (width_ext < WCW'(MIN_DIM)) begin
      width_eff = WCW'(MIN_DIM);
    end else if (width_ext > WCW'(MAX_WIDTH)) begin
      width_eff = WCW'(MAX_WIDTH);
    end
  end

  always_comb begin
    height_eff = height_q;
    if (height_q < DIM_W'(MIN_DIM)) begin
      height_eff = DIM_W'(MIN_DIM);
    end else if (height_q > DIM_W'(HEIGHT_LIMIT)) begin
      height_eff = DIM_W'(HEIGHT_LIMIT);
    end
  end

  assign last_col      = width_eff - WCW'(1);
  assign last_row_full = height_eff - DIM_W'(1);
  assign last_row      = last_row_full[ROW_W-1:0];
  assign div_eff       = (norm_q == '0) ? DIV_W'(1) : norm_q;

  // handshake and position
  logic          en, accept;
  logic [AW-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic          line_end, img_end, produce;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  assign line_end = WCW'(col_q) >= last_col;
  assign img_end  = line_end && (row_q >= last_row);
  assign produce  = (col_q >= AW'(2)) && (row_q >= ROW_W'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (img_end) begin
        col_q <= '0;
        row_q <= '0;
      end else if (line_end) begin
        col_q <= '0;
        row_q <= row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  // stage 1: pixel waits for its line store word
  logic             s1_act_q;
  tag_t             s1_tag_q;
  logic [PIX_W-1:0] s1_px_q;
  logic [AW-1:0]    s1_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_act_q <= 1'b0;
      s1_tag_q <= '0;
    end else if (en) begin
      s1_act_q       <= accept;
      s1_tag_q.valid <= accept && produce;
      s1_tag_q.last  <= img_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= pixel_in_i;
      s1_addr_q <= col_q;
    end
  end

  logic [2*PIX_W-1:0] line_word, wr_word;
  logic               mem_wr_en;

  assign mem_wr_en = en && s1_act_q;

  icv_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (2*PIX_W)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (line_word),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_word)
  );

  logic signed [SUM_W-1:0] row_sum [3];
  tag_t                    win_tag;

  icv_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .act_i     (s1_act_q),
    .tag_i     (s1_tag_q),
    .px_i      (s1_px_q),
    .line_i    (line_word),
    .coef_i    (coef_q),
    .wr_data_o (wr_word),
    .row_sum_o (row_sum),
    .tag_o     (win_tag)
  );

  icv_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .div_i     (div_eff),
    .row_sum_i (row_sum),
    .tag_i     (win_tag),
    .valid_o   (out_valid_o),
    .pixel_o   (pixel_out_o),
    .last_o    (frame_end_o)
  );

  // write-back never lands on the column being read in the same cycle
  `ASSERT_IMPLY(a_mem_no_overlap, clk_i, rst_ni, mem_wr_en && accept, s1_addr_q != col_q)
  `ASSERT_IMPLY(a_col_in_range, clk_i, rst_ni, 1'b1, WCW'(col_q) < WCW'(MAX_WIDTH))
  `ASSERT_NEXT(a_frame_wrap, clk_i, rst_ni, accept && img_end, (col_q == '0) && (row_q == '0))

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 raster convolution filter.
// ----------------------------------------------------------------------------
// Feeds whole grey images under random sender gaps and receiver stalls. A
// behavioral model of the line stores, the window and the flipped kernel
// predicts every filtered pixel and its frame end flag. Each output beat is
// checked in order against that prediction. Covers the reset kernel,
// saturation, a zero divisor, a geometry shrink in mid image and size clamps.
// ----------------------------------------------------------------------------
module testbench;
  import icv_pkg::*;

  localparam int unsigned MAX_W        = 1024;
  localparam int unsigned SETTLE_TICKS = 24;  // pipe is 13 deep

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } filt_pixel_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [PIX_W-1:0]      pixel_in_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PIX_W-1:0]      pixel_out_o;
  logic                  frame_end_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count    = 0;
  int unsigned pixels_sent    = 0;
  int unsigned pixels_checked = 0;
  int unsigned frames_seen    = 0;

  // shadow of the block: registers, line stores, window, raster position
  logic [DIM_W-1:0]  img_width  = 11'd1024;
  logic [DIM_W-1:0]  img_height = 11'd1024;
  logic [DIV_W-1:0]  norm_div   = 8'd1;
  coef_mat_t         kernel     = '0;
  logic [PIX_W-1:0]  line_last [MAX_W];
  logic [PIX_W-1:0]  line_prev [MAX_W];
  logic [PIX_W-1:0]  win_regs  [6];
  logic [ROW_W-1:0]  col_pos = '0;
  logic [ROW_W-1:0]  row_pos = '0;

  filt_pixel_t expected_pixels[$];

  image_convolution_3x3 u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .frame_end_o (frame_end_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    int unsigned d;
    d = v;
    if (d < MIN_DIM) d = MIN_DIM;
    if (d > hi) d = hi;
    return d;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pack_row(input int c0, input int c1, input int c2);
    logic [7:0] b0, b1, b2;
    b0 = c0[7:0];
    b1 = c1[7:0];
    b2 = c2[7:0];
    return {b2, b1, b0};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_row();
    case ($urandom_range(4))
      0: return CFG_DATA_W'($urandom);
      1: return 24'h808080;
      2: return 24'h7F7F7F;
      default: return pack_row(int'($urandom_range(8)) - 4, int'($urandom_range(8)) - 4,
                               int'($urandom_range(8)) - 4);
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] make_pixel(input int unsigned mode);
    case (mode)
      0: return PIX_W'($urandom_range(255));
      1: return $urandom_range(1) ? PIX_MAX : '0;
      2: return PIX_W'($urandom_range(15));
      default: return PIX_MAX - PIX_W'($urandom_range(15));
    endcase
  endfunction

  // One accepted pixel: shift the window, rotate the line stores, and queue
  // the filtered value when the window sits fully inside the image.
  function automatic void predict_filtered(input logic [PIX_W-1:0] px);
    logic [PIX_W-1:0] win [3][3];
    int unsigned w, h, dv, idx, mag, quot;
    int          acc;
    logic        line_end, img_end;
    w   = clamp_dim(img_width, MAX_W);
    h   = clamp_dim(img_height, HEIGHT_LIMIT);
    dv  = (norm_div == 0) ? 1 : norm_div;
    idx = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win_regs[2*r];
      win[r][1] = win_regs[2*r+1];
    end
    win[0][2] = line_prev[idx];
    win[1][2] = line_last[idx];
    win[2][2] = px;
    line_prev[idx] = line_last[idx];
    line_last[idx] = px;
    for (int r = 0; r < 3; r++) begin
      win_regs[2*r]   = win[r][1];
      win_regs[2*r+1] = win[r][2];
    end
    line_end = (col_pos >= w - 1);
    img_end  = line_end && (row_pos >= h - 1);
    if (col_pos >= 2 && row_pos >= 2) begin
      acc = 0;
      // true convolution: kernel taps run against the window flipped
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          acc += int'($signed(kernel[i][j])) * int'(win[2-i][2-j]);
        end
      end
      mag  = (acc < 0) ? -acc : acc;
      quot = mag / dv;
      if (quot > 255) quot = 255;
      expected_pixels.push_back('{pixel: quot[PIX_W-1:0], frame_end: img_end});
    end
    if (img_end) begin
      col_pos = '0;
      row_pos = '0;
    end else if (line_end) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_IMAGE_WIDTH:  img_width  = data[DIM_W-1:0];
      REG_IMAGE_HEIGHT: img_height = data[DIM_W-1:0];
      REG_NORM_DIVISOR: norm_div   = data[DIV_W-1:0];
      REG_COEF_TOP:     kernel[0]  = data;
      REG_COEF_MID:     kernel[1]  = data;
      REG_COEF_BOT:     kernel[2]  = data;
      default: ;
    endcase
  endtask

  task automatic write_kernel(input logic [CFG_DATA_W-1:0] top, input logic [CFG_DATA_W-1:0] mid,
                              input logic [CFG_DATA_W-1:0] bot);
    write_reg(REG_COEF_TOP, top);
    write_reg(REG_COEF_MID, mid);
    write_reg(REG_COEF_BOT, bot);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_filtered(px);
    pixels_sent++;
  endtask

  task automatic send_image(input int unsigned w, input int unsigned h, input int unsigned mode);
    repeat (w * h) send_pixel(make_pixel(mode));
  endtask

  // pipe empty and every border beat flushed through before registers move
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // zero kernel and unit divisor straight out of reset
  task automatic test_reset_kernel();
    write_reg(REG_IMAGE_WIDTH, 24'd3);
    write_reg(REG_IMAGE_HEIGHT, 24'd3);
    send_image(3, 3, 0);
    wait_drain();
  endtask

  task automatic test_kernel_extremes();
    // most negative taps on full-scale pixels, divisor zero acts as one
    write_reg(REG_NORM_DIVISOR, 24'd0);
    write_kernel(24'h808080, 24'h808080, 24'h808080);
    send_image(3, 3, 3);
    send_image(3, 3, 1);
    wait_drain();
    // largest positive taps, largest divisor
    write_reg(REG_NORM_DIVISOR, 24'd255);
    write_kernel(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
    send_image(3, 3, 1);
    wait_drain();
    // a single corner tap shows the kernel flip
    write_reg(REG_IMAGE_WIDTH, 24'd4);
    write_reg(REG_NORM_DIVISOR, 24'd1);
    write_kernel(pack_row(1, 0, 0), 24'h0, 24'h0);
    send_image(4, 3, 0);
    wait_drain();
  endtask

  task automatic test_midimage_shrink();
    write_reg(REG_IMAGE_WIDTH, 24'd8);
    write_reg(REG_IMAGE_HEIGHT, 24'd6);
    write_reg(REG_NORM_DIVISOR, 24'd3);
    write_kernel(pack_row(1, 2, 1), 24'h0, pack_row(-1, -2, -1));
    // three full lines plus five pixels of the fourth
    repeat (3 * 8 + 5) send_pixel(make_pixel(0));
    wait_drain();
    write_reg(REG_IMAGE_WIDTH, 24'd4);
    write_reg(REG_IMAGE_HEIGHT, 24'd3);
    // column and row are now past the new bounds: this beat ends the image
    send_pixel(make_pixel(0));
    send_image(4, 3, 0);
    wait_drain();
  endtask

  task automatic test_random_images(input int unsigned n_pixels, input int unsigned idle_pct,
                                    input int unsigned stall_pct);
    int unsigned      start, w_eff, h_eff;
    logic [DIM_W-1:0] w, h;
    logic [DIV_W-1:0] dv;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = pixels_sent;
    while (pixels_sent - start < n_pixels) begin
      case ($urandom_range(9))
        0:       w = DIM_W'($urandom_range(2));
        1, 2:    w = DIM_W'($urandom_range(25, 64));
        default: w = DIM_W'($urandom_range(3, 24));
      endcase
      h = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(2)) : DIM_W'($urandom_range(3, 8));
      case ($urandom_range(5))
        0:       dv = 8'd0;
        1:       dv = 8'd1;
        2:       dv = 8'hFF;
        default: dv = DIV_W'($urandom_range(1, 64));
      endcase
      wait_drain();
      write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
      write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
      write_reg(REG_NORM_DIVISOR, CFG_DATA_W'(dv));
      write_kernel(random_row(), random_row(), random_row());
      w_eff = clamp_dim(w, MAX_W);
      h_eff = clamp_dim(h, HEIGHT_LIMIT);
      send_image(w_eff, h_eff, $urandom_range(3));
    end
    wait_drain();
  endtask

  // sizes below the minimum of three fall back to three
  task automatic test_size_clamps();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_NORM_DIVISOR, 24'd16);
    write_kernel(pack_row(-1, -1, -1), pack_row(-1, 8, -1), pack_row(-1, -1, -1));
    write_reg(REG_IMAGE_WIDTH, 24'd0);
    write_reg(REG_IMAGE_HEIGHT, 24'd1);
    send_image(3, 3, 0);
    wait_drain();
    write_reg(REG_IMAGE_WIDTH, 24'd2);
    write_reg(REG_IMAGE_HEIGHT, 24'd0);
    send_image(3, 3, 0);
    wait_drain();
  endtask

  always @(posedge clk_i) begin : check_outputs
    filt_pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected beat pixel=%0d frame_end=%0b",
                                  pixel_out_o, frame_end_o));
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (pixel_out_o !== want.pixel)
          report_mismatch($sformatf("pixel_out got %0d want %0d", pixel_out_o, want.pixel));
        if (frame_end_o !== want.frame_end)
          report_mismatch($sformatf("frame_end got %b want %b", frame_end_o, want.frame_end));
        if (frame_end_o === 1'b1) frames_seen++;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    send_idle_pct  = 38;
    recv_stall_pct = 53;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_kernel();
    test_kernel_extremes();
    test_midimage_shrink();
    test_random_images(220, 38, 53);
    test_random_images(220, 53, 38);
    test_random_images(220, 0, 0);
    test_size_clamps();

    wait_drain();
    $display("Sent %0d pixels, checked %0d filtered pixels over %0d frames.",
             pixels_sent, pixels_checked, frames_seen);
    $display("Covered reset kernel, tap extremes, zero divisor, mid-image shrink, size clamps.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d beats still expected", expected_pixels.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
